@@ sv/gsts_pkg.sv @@
`default_nettype none
package gsts_pkg;
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int INV_GAIN_Q16 = 39796;
  localparam int XW = 36;
  localparam int ZW = 18;

  localparam logic [1:0] CFG_SPEED = 2'd0;
  localparam logic [1:0] CFG_MAX_TURN = 2'd1;
  localparam logic [1:0] CFG_TOL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VPRE, ST_VITER, ST_VMUL, ST_VFIN, ST_TURN, ST_RMUL, ST_RPRE,
    ST_RITER, ST_UPD, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic set_goal;
    logic vpre;
    logic viter;
    logic vmul;
    logic vfin;
    logic turn;
    logic rmul;
    logic rpre;
    logic riter;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic req_goal;
    logic armed;
    logic zero_delta;
    logic reached;
    logic iter_last;
  } sts_t;

  function automatic logic signed [ZW-1:0] atan_q13(input logic [4:0] i);
    case (i)
      5'd0: atan_q13 = 18'sd6434;
      5'd1: atan_q13 = 18'sd3798;
      5'd2: atan_q13 = 18'sd2007;
      5'd3: atan_q13 = 18'sd1019;
      5'd4: atan_q13 = 18'sd511;
      5'd5: atan_q13 = 18'sd256;
      5'd6: atan_q13 = 18'sd128;
      5'd7: atan_q13 = 18'sd64;
      5'd8: atan_q13 = 18'sd32;
      5'd9: atan_q13 = 18'sd16;
      5'd10: atan_q13 = 18'sd8;
      5'd11: atan_q13 = 18'sd4;
      5'd12: atan_q13 = 18'sd2;
      5'd13: atan_q13 = 18'sd1;
      default: atan_q13 = 18'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ sv/gsts_if.sv @@
`default_nettype none
interface gsts_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  modport source(output valid, req_type, goal_x, goal_y, input ready);
  modport sink(input valid, req_type, goal_x, goal_y, output ready);
endinterface

interface gsts_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic [39:0] distance_travelled;
  logic goal_active;
  logic goal_reached;
  modport source(output valid, pos_x, pos_y, heading, distance_travelled, goal_active,
                 goal_reached, input ready);
  modport sink(input valid, pos_x, pos_y, heading, distance_travelled, goal_active,
               goal_reached, output ready);
endinterface
`default_nettype wire

@@ sv/gsts_ctrl.sv @@
`default_nettype none
module gsts_ctrl import gsts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ST_VPRE;
        end
      end
      ST_VPRE: begin
        if (sts.req_goal) begin
          cmd.set_goal = 1'b1;
          state_nxt = ST_OUT;
        end else if (!sts.armed) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.vpre = 1'b1;
          state_nxt = sts.zero_delta ? ST_VFIN : ST_VITER;
        end
      end
      ST_VITER: begin
        cmd.viter = 1'b1;
        if (sts.iter_last) state_nxt = ST_VMUL;
      end
      ST_VMUL: begin
        cmd.vmul = 1'b1;
        state_nxt = ST_VFIN;
      end
      ST_VFIN: begin
        cmd.vfin = 1'b1;
        state_nxt = ST_TURN;
      end
      ST_TURN: begin
        cmd.turn = 1'b1;
        state_nxt = sts.reached ? ST_OUT : ST_RMUL;
      end
      ST_RMUL: begin
        cmd.rmul = 1'b1;
        state_nxt = ST_RPRE;
      end
      ST_RPRE: begin
        cmd.rpre = 1'b1;
        state_nxt = ST_RITER;
      end
      ST_RITER: begin
        cmd.riter = 1'b1;
        if (sts.iter_last) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_VPRE) else $error("accept did not start work");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

@@ sv/gsts_dp.sv @@
`default_nettype none
module gsts_dp import gsts_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  output sts_t sts,
  input  wire logic in_req_type,
  input  wire logic signed [31:0] in_goal_x,
  input  wire logic signed [31:0] in_goal_y,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [20:0] cfg_wdata,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [15:0] heading,
  output logic [39:0] odo,
  output logic armed,
  output logic reached
);
  localparam int NI = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
  localparam logic [4:0] LAST = 5'(NI - 1);

  logic [20:0] speed_r, tol_r;
  logic [14:0] mt_r;
  logic signed [31:0] rx_r, ry_r, tx_r, ty_r, gx_r, gy_r;
  logic signed [15:0] hd_r;
  logic [39:0] odo_r;
  logic armed_r, reached_r, req_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [4:0] it_r;
  logic neg_r;
  logic [33:0] dist_r;
  logic [20:0] stp_r;
  logic [52:0] prod_r;

  logic signed [32:0] dx, dy;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic dir;
  logic signed [ZW-1:0] zc, diff, mts;
  logic signed [16:0] nh;
  logic signed [33:0] sx, sy;

  assign dx = 33'(tx_r) - 33'(rx_r);
  assign dy = 33'(ty_r) - 33'(ry_r);
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign at = atan_q13(it_r);
  assign dir = cmd.viter ? !y_r[XW-1] : !z_r[ZW-1];
  assign zc = (z_r > ZW'(PI_Q13)) ? ZW'(PI_Q13) :
              (z_r < -ZW'(PI_Q13)) ? -ZW'(PI_Q13) : z_r;
  assign mts = ZW'({1'b0, mt_r});
  always_comb begin
    diff = z_r - ZW'(hd_r);
    if (diff > mts) diff = mts;
    if (diff < -mts) diff = -mts;
  end
  assign nh = 17'(hd_r) + 17'(diff);
  assign sx = 34'(rx_r) + 34'(x_r);
  assign sy = 34'(ry_r) + 34'(y_r);

  assign sts.req_goal = req_r;
  assign sts.armed = armed_r;
  assign sts.zero_delta = (dx == '0) && (dy == '0);
  assign sts.reached = dist_r < 34'(tol_r);
  assign sts.iter_last = it_r == LAST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 21'd32768;
      mt_r <= 15'd819;
      tol_r <= 21'd6554;
      rx_r <= '0; ry_r <= '0; tx_r <= '0; ty_r <= '0;
      hd_r <= '0; odo_r <= '0; armed_r <= 1'b0; reached_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPEED: speed_r <= cfg_wdata;
          CFG_MAX_TURN: mt_r <= cfg_wdata[14:0];
          CFG_TOL: tol_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) reached_r <= 1'b0;
      if (cmd.set_goal) begin
        tx_r <= gx_r; ty_r <= gy_r; armed_r <= 1'b1;
      end
      if (cmd.turn) begin
        if (sts.reached) begin
          armed_r <= 1'b0; reached_r <= 1'b1;
        end else hd_r <= nh[15:0];
      end
      if (cmd.upd) begin
        rx_r <= (sx > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (sx < -34'sd2147483648) ? 32'sh80000000 : sx[31:0];
        ry_r <= (sy > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (sy < -34'sd2147483648) ? 32'sh80000000 : sy[31:0];
        odo_r <= ({1'b0, odo_r} + 41'(stp_r) > 41'h0FFFFFFFFFF) ? 40'hFFFFFFFFFF :
                 odo_r + 40'(stp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type; gx_r <= in_goal_x; gy_r <= in_goal_y;
    end
    if (cmd.vpre) begin
      it_r <= '0;
      if (sts.zero_delta) begin
        dist_r <= '0; z_r <= '0;
      end else if (dx[32]) begin
        x_r <= -XW'(dx); y_r <= -XW'(dy);
        z_r <= dy[32] ? -ZW'(PI_Q13) : ZW'(PI_Q13);
      end else begin
        x_r <= XW'(dx); y_r <= XW'(dy); z_r <= '0;
      end
    end
    if (cmd.viter || cmd.riter) begin
      it_r <= it_r + 5'd1;
      if (cmd.viter) begin
        if (dir) begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
        end
      end else begin
        if (dir) begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
        end
      end
    end
    if (cmd.vmul) begin
      prod_r <= 53'(x_r[XW-1] ? 36'd0 : x_r) * 53'(INV_GAIN_Q16) + 53'd32768;
    end
    if (cmd.vfin) begin
      if (!sts.zero_delta) dist_r <= 34'(prod_r >> 16);
      z_r <= sts.zero_delta ? '0 : zc;
    end
    if (cmd.turn) begin
      stp_r <= (34'(speed_r) < dist_r) ? speed_r : dist_r[20:0];
      z_r <= ZW'(nh);
    end
    if (cmd.rmul) prod_r <= 53'(stp_r) * 53'(INV_GAIN_Q16) + 53'd32768;
    if (cmd.rpre) begin
      x_r <= XW'(prod_r >> 16); y_r <= '0; it_r <= '0;
      if (z_r > ZW'(HALF_PI_Q13)) begin
        z_r <= z_r - ZW'(PI_Q13); neg_r <= 1'b1;
      end else if (z_r < -ZW'(HALF_PI_Q13)) begin
        z_r <= z_r + ZW'(PI_Q13); neg_r <= 1'b1;
      end else neg_r <= 1'b0;
    end
    if (cmd.riter && sts.iter_last && neg_r) begin
      if (dir) begin
        x_r <= -(x_r - ys); y_r <= -(y_r + xs);
      end else begin
        x_r <= -(x_r + ys); y_r <= -(y_r - xs);
      end
    end
  end

  assign pos_x = rx_r;
  assign pos_y = ry_r;
  assign heading = hd_r;
  assign odo = odo_r;
  assign armed = armed_r;
  assign reached = reached_r;

`ifndef SYNTHESIS
  a_reach_clears: assert property (@(posedge clk) disable iff (!rst_n)
    reached_r |-> !armed_r) else $error("reached while armed");
  a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.turn && !sts.reached |=>
    $signed(hd_r - $past(hd_r)) <= $signed({1'b0, $past(mt_r)}) &&
    $signed($past(hd_r) - hd_r) <= $signed({1'b0, $past(mt_r)}))
    else $error("turn exceeds limit");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> stp_r <= speed_r) else $error("step above speed");
`endif
endmodule
`default_nettype wire

@@ sv/goal_seek_turn_limited_step.sv @@
// Path: a set-goal or idle step goes straight to the result; a moving step runs vectoring,
// the turn and rotation first. Ready returns in the cycle after the result is taken.
// Throughput: one word at a time; the shared CORDIC iterates once per cycle, vectoring
// then rotation, and sets the rate.
// Reset (rst_n low, synchronous): pose, goal and odometer clear, goal disarmed,
// registers return to speed 32768, max_turn 819, tolerance 6554.
`default_nettype none
module goal_seek_turn_limited_step import gsts_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gsts_in_if.sink in_ch,
  gsts_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [20:0] cfg_wdata
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready, out_valid;

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;

  gsts_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_ch.valid && in_ready), .out_ready(out_ch.ready),
    .sts, .in_ready, .out_valid, .cmd
  );

  gsts_dp #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_req_type(in_ch.req_type), .in_goal_x(in_ch.goal_x), .in_goal_y(in_ch.goal_y),
    .cfg_we, .cfg_index, .cfg_wdata,
    .pos_x(out_ch.pos_x), .pos_y(out_ch.pos_y), .heading(out_ch.heading),
    .odo(out_ch.distance_travelled), .armed(out_ch.goal_active),
    .reached(out_ch.goal_reached)
  );
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  import gsts_pkg::*;

  localparam int LIMIT = 600000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 75;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] hd;
    logic [39:0] odo;
    logic act;
    logic rch;
  } pose_t;

  typedef struct {
    logic req;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    bit typed;
    pose_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [20:0] cfg_wdata = '0;

  gsts_in_if in_ch();
  gsts_out_if out_ch();

  goal_seek_turn_limited_step u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // predicted block state
  longint rob_x, rob_y, tgt_x, tgt_y;
  int rob_hd;
  longint unsigned odo_acc, spd, mturn, tol;
  bit armed;

  pose_t pose_queue[$];
  row_t rows[$];
  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  function automatic int arctan_q13(int i);
    int tab[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 14) ? tab[i] : 0;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pose_t seek_step(logic req, logic signed [31:0] gx,
                                      logic signed [31:0] gy);
    pose_t r;
    bit reached;
    longint x, y, nx, mx, my;
    longint unsigned span, stp;
    int z, bearing, diff, mt;
    bit neg;
    reached = 0;
    if (req) begin
      tgt_x = gx;
      tgt_y = gy;
      armed = 1;
    end else if (armed) begin
      x = tgt_x - rob_x;
      y = tgt_y - rob_y;
      mt = int'(mturn);
      if (x == 0 && y == 0) begin
        span = 0;
        bearing = 0;
      end else begin
        z = 0;
        if (x < 0) begin
          z = (y >= 0) ? PI_Q13 : -PI_Q13;
          x = -x;
          y = -y;
        end
        for (int i = 0; i < 16; i++) begin
          if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += arctan_q13(i);
          end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= arctan_q13(i);
          end
          x = nx;
        end
        if (x < 0) x = 0;
        span = (longint'(x) * INV_GAIN_Q16 + 32768) >> 16;
        if (z > PI_Q13) z = PI_Q13;
        if (z < -PI_Q13) z = -PI_Q13;
        bearing = z;
      end
      if (span < tol) begin
        armed = 0;
        reached = 1;
      end else begin
        stp = (spd < span) ? spd : span;
        diff = bearing - rob_hd;
        if (diff > mt) diff = mt;
        if (diff < -mt) diff = -mt;
        rob_hd += diff;
        // rotate the gain-compensated step onto the new heading
        x = longint'((stp * INV_GAIN_Q16 + 32768) >> 16);
        y = 0;
        z = rob_hd;
        neg = 0;
        if (z > HALF_PI_Q13) begin
          z -= PI_Q13;
          neg = 1;
        end else if (z < -HALF_PI_Q13) begin
          z += PI_Q13;
          neg = 1;
        end
        for (int i = 0; i < 16; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= arctan_q13(i);
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += arctan_q13(i);
          end
          x = nx;
        end
        mx = neg ? -x : x;
        my = neg ? -y : y;
        rob_x = sat32(rob_x + mx);
        rob_y = sat32(rob_y + my);
        if (odo_acc > 64'hFF_FFFF_FFFF - stp) odo_acc = 64'hFF_FFFF_FFFF;
        else odo_acc += stp;
      end
    end
    r.px = rob_x[31:0];
    r.py = rob_y[31:0];
    r.hd = rob_hd[15:0];
    r.odo = odo_acc[39:0];
    r.act = armed;
    r.rch = reached;
    return r;
  endfunction

  task automatic send_word(logic req, logic signed [31:0] gx, logic signed [31:0] gy,
                           bit typed, pose_t want);
    pose_t p;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.req_type = req;
    in_ch.goal_x = gx;
    in_ch.goal_y = gy;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    p = seek_step(req, gx, gy);
    pose_queue = {pose_queue, (typed ? want : p)};
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [20:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SPEED: spd = v;
      CFG_MAX_TURN: mturn = v & 21'h7FFF;
      CFG_TOL: tol = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pose_queue.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_row(logic req, logic signed [31:0] gx, logic signed [31:0] gy,
                         bit typed, logic act, logic rch);
    row_t r;
    r.req = req;
    r.gx = gx;
    r.gy = gy;
    r.typed = typed;
    r.want = '{px: 0, py: 0, hd: 0, odo: 0, act: act, rch: rch};
    rows = {rows, r};
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    pose_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("goal_seek_turn_limited_step regression: fail");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pose_queue.size() == 0) begin
        $error("unexpected word");
        errors++;
      end else begin
        e = pose_queue.pop_front();
        if (out_ch.pos_x !== e.px) begin
          $error("pos_x exp %0d got %0d", e.px, out_ch.pos_x); errors++;
        end
        if (out_ch.pos_y !== e.py) begin
          $error("pos_y exp %0d got %0d", e.py, out_ch.pos_y); errors++;
        end
        if (out_ch.heading !== e.hd) begin
          $error("heading exp %0d got %0d", e.hd, out_ch.heading); errors++;
        end
        if (out_ch.distance_travelled !== e.odo) begin
          $error("distance_travelled exp %0d got %0d", e.odo, out_ch.distance_travelled);
          errors++;
        end
        if (out_ch.goal_active !== e.act) begin
          $error("goal_active exp %0b got %0b", e.act, out_ch.goal_active); errors++;
        end
        if (out_ch.goal_reached !== e.rch) begin
          $error("goal_reached exp %0b got %0b", e.rch, out_ch.goal_reached); errors++;
        end
      end
    end
  end

  initial begin
    longint unsigned cfg_tab[PHASES][3] = '{
      '{32768, 819, 6554}, '{1048576, 25736, 1048576}, '{0, 0, 0},
      '{65536, 25736, 0}, '{1048576, 100, 200}, '{5000, 3000, 40000}};
    pose_t nil;
    int sent, nsteps;
    logic signed [31:0] gx, gy;
    nil = '{px: 0, py: 0, hd: 0, odo: 0, act: 0, rch: 0};
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.goal_x = '0;
    in_ch.goal_y = '0;
    out_ch.ready = 1'b0;
    rob_x = 0; rob_y = 0; tgt_x = 0; tgt_y = 0; rob_hd = 0; odo_acc = 0; armed = 0;
    spd = 32768; mturn = 819; tol = 6554;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: idle step, extreme goals, on-goal arrival, then short moves
    add_row(1'b0, 32'sd0, 32'sd0, 1'b1, 1'b0, 1'b0);
    add_row(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b0);
    add_row(1'b1, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b1, 1'b0);
    add_row(1'b1, 32'sd0, 32'sd0, 1'b1, 1'b1, 1'b0);
    add_row(1'b0, 32'sd0, 32'sd0, 1'b1, 1'b0, 1'b1);
    add_row(1'b0, 32'sh1234_5678, 32'sh0F0F_0F0F, 1'b1, 1'b0, 1'b0);
    add_row(1'b1, 32'sh0003_0000, -32'sh0002_0000, 1'b0, 1'b0, 1'b0);
    repeat (4) add_row(1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0);
    add_row(1'b1, -32'sh0005_0000, -32'sd1, 1'b0, 1'b0, 1'b0);
    repeat (4) add_row(1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0);
    add_row(1'b1, -32'sh0004_0000, 32'sd1, 1'b0, 1'b0, 1'b0);
    repeat (3) add_row(1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0);
    add_row(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, 1'b0);
    repeat (3) add_row(1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0);
    foreach (rows[i]) send_word(rows[i].req, rows[i].gx, rows[i].gy, rows[i].typed,
                                rows[i].want);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_write(CFG_SPEED, 21'(cfg_tab[ph][0]));
      cfg_write(CFG_MAX_TURN, 21'(cfg_tab[ph][1]));
      cfg_write(CFG_TOL, 21'(cfg_tab[ph][2]));
      if (ph == 2) cfg_write(CFG_UNUSED, 21'h1FFFFF);
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 84; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 84; end
        default: begin gap_pct = 11; stall_pct = 11; end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) begin
        case ($urandom_range(19))
          0, 1: begin
            gx = $urandom;
            gy = $urandom;
          end
          2: begin  // goal on the robot itself
            gx = rob_x[31:0];
            gy = rob_y[31:0];
          end
          default: begin
            gx = 32'(sat32(rob_x + $signed($urandom_range(32'h100000)) - 32'sh80000));
            gy = 32'(sat32(rob_y + $signed($urandom_range(32'h100000)) - 32'sh80000));
          end
        endcase
        send_word(1'b1, gx, gy, 1'b0, nil);
        sent++;
        nsteps = $urandom_range(1, 30);
        for (int k = 0; k < nsteps && sent < PHASE_WORDS; k++) begin
          // step words only; goal_y is always junk and goal_x now and then
          send_word(1'b0, ($urandom_range(3) == 0) ? $urandom : 32'd0, $urandom, 1'b0, nil);
          sent++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("goal_seek_turn_limited_step regression: pass");
    end else begin
      $display("goal_seek_turn_limited_step regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ goal_seek_turn_limited_step.f @@
sv/gsts_pkg.sv
sv/gsts_if.sv
sv/gsts_ctrl.sv
sv/gsts_dp.sv
sv/goal_seek_turn_limited_step.sv
bench/testbench.sv
